// File: src/mesh_area_volume_accumulator_assert.svh
// Assertion macros for the mesh area and volume accumulator.
// Used at the end of the top level; relies on clk_i and rst_ni there.
`ifndef MESH_AREA_VOLUME_ACCUMULATOR_ASSERT_SVH
`define MESH_AREA_VOLUME_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MAVA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MAVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mava_pkg.sv
// Shared types and constants of the mesh area and volume accumulator.
// No dependencies; every other file but the assert header imports it.
package mava_pkg;

  localparam int FIELD_BITS      = 20;
  localparam int COORD_BITS_DEF  = 20;
  localparam int COUNT_BITS      = 32;
  localparam int SUM_BITS        = 64;
  localparam int OUT_BITS        = 63;
  localparam int LANES           = 3;
  localparam int LANE_STEPS      = 5;
  localparam int LANE_CNT_BITS   = 3;

  // Mode register codes; the unused code behaves as both.
  localparam logic [1:0] MODE_AREA   = 2'd0;
  localparam logic [1:0] MODE_VOLUME = 2'd1;
  localparam logic [1:0] MODE_BOTH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_MERGE,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Step strobes from the sequencer to every lane.
  typedef struct packed {
    logic prod;
    logic diff;
    logic sq_lo;
    logic sq_mid;
    logic sq_hi;
  } lane_ctrl_t;

endpackage

// File: src/mava_intf.sv
// Channel interfaces: triangle input, result output and mode write.
// Depends on mava_pkg for field widths.
interface mava_tri_if;
  import mava_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] a_x;
  logic signed [FIELD_BITS-1:0] a_y;
  logic signed [FIELD_BITS-1:0] a_z;
  logic signed [FIELD_BITS-1:0] b_x;
  logic signed [FIELD_BITS-1:0] b_y;
  logic signed [FIELD_BITS-1:0] b_z;
  logic signed [FIELD_BITS-1:0] c_x;
  logic signed [FIELD_BITS-1:0] c_y;
  logic signed [FIELD_BITS-1:0] c_z;
  logic                         last_triangle;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  last_triangle, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                last_triangle, output ready);
endinterface

interface mava_res_if;
  import mava_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] triangle_count;
  logic [OUT_BITS-1:0]   twice_area_sum;
  logic [OUT_BITS-1:0]   six_volume_abs;
  modport source (output valid, triangle_count, twice_area_sum, six_volume_abs,
                  input ready);
  modport sink (input valid, triangle_count, twice_area_sum, six_volume_abs,
                output ready);
endinterface

interface mava_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

// File: src/mava_lane.sv
// One axis lane: a cross-product component squared over three steps, and one
// term of the triple product. Depends on mava_pkg for the step strobes.
module mava_lane #(
  parameter int CB = mava_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  mava_pkg::lane_ctrl_t          ctrl_i,
  input  logic signed [CB-1:0]          a_i,
  input  logic signed [CB-1:0]          b1_i,
  input  logic signed [CB-1:0]          b2_i,
  input  logic signed [CB-1:0]          c1_i,
  input  logic signed [CB-1:0]          c2_i,
  input  logic signed [CB:0]            u1_i,
  input  logic signed [CB:0]            u2_i,
  input  logic signed [CB:0]            v1_i,
  input  logic signed [CB:0]            v2_i,
  output logic [2*(2*CB+1)-1:0]         sq_o,
  output logic signed [3*CB:0]          t_o
);
  import mava_pkg::*;

  localparam int PW  = 2 * (CB + 1);
  localparam int KW  = 2 * CB + 1;
  localparam int KH  = KW / 2;
  localparam int KL  = KW - KH;
  localparam int SQW = 2 * KW;
  localparam int QW  = 2 * CB;
  localparam int WW  = 2 * CB + 1;
  localparam int TW  = 3 * CB + 1;

  logic signed [PW-1:0] p1_q, p2_q, p1_d, p2_d;
  logic signed [QW-1:0] q1_q, q2_q, q1_d, q2_d;
  logic signed [PW:0]   kdiff;
  logic [KW-1:0]        k_q;
  logic signed [WW-1:0] w_q;
  logic signed [TW-1:0] t_q, t_d;
  logic [KL-1:0]        op_a, op_b;
  logic [2*KL-1:0]      prod;
  logic [SQW-1:0]       sq_q;

  // Edge and vertex products.
  assign p1_d = u1_i * v2_i;
  assign p2_d = u2_i * v1_i;
  assign q1_d = b1_i * c2_i;
  assign q2_d = b2_i * c1_i;
  assign kdiff = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};
  assign t_d = a_i * w_q;

  // One shared multiplier walks the low, cross and high partial squares.
  always_comb begin
    op_a = k_q[KL-1:0];
    op_b = k_q[KL-1:0];
    if (ctrl_i.sq_mid) begin
      op_a = KL'(k_q[KW-1:KL]);
    end else if (ctrl_i.sq_hi) begin
      op_a = KL'(k_q[KW-1:KL]);
      op_b = KL'(k_q[KW-1:KL]);
    end
  end
  assign prod = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      q1_q <= q1_d;
      q2_q <= q2_d;
    end
    if (ctrl_i.diff) begin
      k_q <= kdiff[PW] ? KW'(-kdiff) : KW'(kdiff);
      w_q <= WW'({q1_q[QW-1], q1_q} - {q2_q[QW-1], q2_q});
    end
    if (ctrl_i.sq_lo) begin
      t_q  <= t_d;
      sq_q <= SQW'(prod);
    end
    if (ctrl_i.sq_mid) begin
      sq_q <= sq_q + (SQW'(prod) << (KL + 1));
    end
    if (ctrl_i.sq_hi) begin
      sq_q <= sq_q + (SQW'(prod) << (2 * KL));
    end
  end

  assign sq_o = sq_q;
  assign t_o  = t_q;

endmodule

// File: src/mava_isqrt.sv
// Iterative floor square root, one root bit per cycle.
// Depends on mava_pkg only through the shared import convention.
module mava_isqrt #(
  parameter int RW = 2 * mava_pkg::COORD_BITS_DEF + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [2*RW-1:0] op_i,
  output logic          busy_o,
  output logic [RW-1:0] root_o
);
  import mava_pkg::*;

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] opr_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic [RW+2:0]   rem_sh, trial, rem_sub;
  logic            take;

  // Bring down the next bit pair and try the trial divisor.
  assign rem_sh  = {rem_q, opr_q[2*RW-1:2*RW-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign take    = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opr_q  <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      opr_q  <= opr_q << 2;
      rem_q  <= take ? rem_sub[RW:0] : rem_sh[RW:0];
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// File: src/mesh_area_volume_accumulator.sv
// Top level: sequencer, three axis lanes, merge stage, square root and sums.
// Depends on mava_pkg, mava_intf, mava_lane, mava_isqrt and the assert header.

// The block takes one triangle at a time. A triangle is accepted when the
// block is idle. The three lanes then run their product, difference and low,
// cross and high square steps, and the merge follows. The square-root stage
// finds one root bit per cycle and then hands the root over, and the
// accumulate step adds the root and the volume term to the sums. The
// square-root loop takes most of the time per item. On a last triangle, the
// emit state moves the sums into the output register once that register no
// longer holds an unread result. The register then holds the result while
// the next triangle is being taken.
// The mode register may be written at any time and is sampled per triangle.
module mesh_area_volume_accumulator #(
  parameter int COORD_BITS = mava_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mava_tri_if.sink   tri_in,
  mava_res_if.source res_out,
  mava_cfg_if.sink   cfg
);
  import mava_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int KW  = 2 * CB + 1;
  localparam int SQW = 2 * KW;
  localparam int RW  = KW + 1;
  localparam int SSW = 2 * RW;
  localparam int TW  = 3 * CB + 1;
  localparam int VW  = TW + 2;
  localparam logic [SUM_BITS:0] AREA_MAX_X = {2'b00, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS:0] VOL_MAX_X = {2'b00, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS:0] VOL_MIN_X = -VOL_MAX_X;

  state_e state_q, state_d;
  logic [LANE_CNT_BITS-1:0] lane_cnt_q;
  logic [1:0] mode_q;
  logic item_area_q, item_vol_q, item_last_q;
  logic signed [CB-1:0] a_q [LANES];
  logic signed [CB-1:0] b_q [LANES];
  logic signed [CB-1:0] c_q [LANES];
  logic signed [CB:0]   u [LANES];
  logic signed [CB:0]   v [LANES];
  logic [SQW-1:0]       sq [LANES];
  logic signed [TW-1:0] t [LANES];
  lane_ctrl_t lane_ctrl;
  logic [SSW-1:0] sq_sum;
  logic signed [VW-1:0] vold_q;
  logic root_start, root_busy;
  logic [RW-1:0] root;
  logic [SUM_BITS-1:0] area_q, area_d;
  logic signed [SUM_BITS-1:0] vol_q, vol_d;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [SUM_BITS:0] area_ext;
  logic signed [SUM_BITS:0] vol_ext;
  logic [SUM_BITS-1:0] vol_mag;
  logic in_fire, emit_fire, out_valid_q;
  logic [COUNT_BITS-1:0] out_cnt_q;
  logic [OUT_BITS-1:0] out_area_q, out_vol_q;

  assign in_fire   = tri_in.valid && tri_in.ready;
  assign tri_in.ready = (state_q == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || res_out.ready);

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BOTH;
    end else if (cfg.valid) begin
      mode_q <= cfg.mode;
    end
  end

  // Capture the triangle, keeping the low COORD_BITS of each coordinate.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q[0] <= tri_in.a_x[CB-1:0];
      a_q[1] <= tri_in.a_y[CB-1:0];
      a_q[2] <= tri_in.a_z[CB-1:0];
      b_q[0] <= tri_in.b_x[CB-1:0];
      b_q[1] <= tri_in.b_y[CB-1:0];
      b_q[2] <= tri_in.b_z[CB-1:0];
      c_q[0] <= tri_in.c_x[CB-1:0];
      c_q[1] <= tri_in.c_y[CB-1:0];
      c_q[2] <= tri_in.c_z[CB-1:0];
      item_last_q <= tri_in.last_triangle;
      item_area_q <= (mode_q != MODE_VOLUME);
      item_vol_q  <= (mode_q != MODE_AREA);
    end
  end

  // Edges b - a and c - b, one bit wider than the coordinates.
  for (genvar j = 0; j < LANES; j++) begin : g_edge
    assign u[j] = {b_q[j][CB-1], b_q[j]} - {a_q[j][CB-1], a_q[j]};
    assign v[j] = {c_q[j][CB-1], c_q[j]} - {b_q[j][CB-1], b_q[j]};
  end

  // Lane step strobes from the sequencer count.
  always_comb begin
    lane_ctrl        = '0;
    lane_ctrl.prod   = (state_q == ST_LANE) && (lane_cnt_q == LANE_CNT_BITS'(0));
    lane_ctrl.diff   = (state_q == ST_LANE) && (lane_cnt_q == LANE_CNT_BITS'(1));
    lane_ctrl.sq_lo  = (state_q == ST_LANE) && (lane_cnt_q == LANE_CNT_BITS'(2));
    lane_ctrl.sq_mid = (state_q == ST_LANE) && (lane_cnt_q == LANE_CNT_BITS'(3));
    lane_ctrl.sq_hi  = (state_q == ST_LANE) && (lane_cnt_q == LANE_CNT_BITS'(4));
  end

  // One lane per axis; each uses the two other axes.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    localparam int J1 = (j + 1) % LANES;
    localparam int J2 = (j + 2) % LANES;
    mava_lane #(.CB(CB)) u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .a_i    (a_q[j]),
      .b1_i   (b_q[J1]),
      .b2_i   (b_q[J2]),
      .c1_i   (c_q[J1]),
      .c2_i   (c_q[J2]),
      .u1_i   (u[J1]),
      .u2_i   (u[J2]),
      .v1_i   (v[J1]),
      .v2_i   (v[J2]),
      .sq_o   (sq[j]),
      .t_o    (t[j])
    );
  end

  // Merge: squared norm of the cross product feeds the root unit.
  assign sq_sum = SSW'(sq[0]) + SSW'(sq[1]) + SSW'(sq[2]);
  assign root_start = (state_q == ST_MERGE);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MERGE) begin
      vold_q <= VW'(t[0]) + VW'(t[1]) + VW'(t[2]);
    end
  end

  mava_isqrt #(.RW(RW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .op_i    (sq_sum),
    .busy_o  (root_busy),
    .root_o  (root)
  );

  // Saturating accumulation.
  always_comb begin
    area_ext = {1'b0, area_q} + (SUM_BITS+1)'(root);
    vol_ext  = (SUM_BITS+1)'(vol_q) + (SUM_BITS+1)'(vold_q);
    area_d   = area_q;
    vol_d    = vol_q;
    if (item_area_q) begin
      area_d = (area_ext > AREA_MAX_X) ? AREA_MAX_X[SUM_BITS-1:0] : area_ext[SUM_BITS-1:0];
    end
    if (item_vol_q) begin
      if (vol_ext > VOL_MAX_X) begin
        vol_d = VOL_MAX_X[SUM_BITS-1:0];
      end else if (vol_ext < VOL_MIN_X) begin
        vol_d = VOL_MIN_X[SUM_BITS-1:0];
      end else begin
        vol_d = vol_ext[SUM_BITS-1:0];
      end
    end
  end

  assign vol_mag = vol_q[SUM_BITS-1] ? SUM_BITS'(-vol_q) : SUM_BITS'(vol_q);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_LANE;
      ST_LANE:  if (lane_cnt_q == LANE_CNT_BITS'(LANE_STEPS - 1)) state_d = ST_MERGE;
      ST_MERGE: state_d = ST_ROOT;
      ST_ROOT:  if (!root_busy) state_d = ST_ACC;
      ST_ACC:   state_d = item_last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (emit_fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control and sum registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_cnt_q  <= '0;
      area_q      <= '0;
      vol_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_LANE) begin
        lane_cnt_q <= lane_cnt_q + 1'b1;
      end else begin
        lane_cnt_q <= '0;
      end
      if (state_q == ST_ACC) begin
        area_q <= area_d;
        vol_q  <= vol_d;
        if (cnt_q != {COUNT_BITS{1'b1}}) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (emit_fire) begin
        area_q <= '0;
        vol_q  <= '0;
        cnt_q  <= '0;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_cnt_q  <= cnt_q;
      out_area_q <= item_area_q ? area_q[OUT_BITS-1:0] : '0;
      out_vol_q  <= item_vol_q ? vol_mag[OUT_BITS-1:0] : '0;
    end
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.triangle_count = out_cnt_q;
  assign res_out.twice_area_sum = out_area_q;
  assign res_out.six_volume_abs = out_vol_q;

`include "mesh_area_volume_accumulator_assert.svh"

  `MAVA_ASSERT_NEXT(a_accept_starts_lanes, in_fire, state_q == ST_LANE, "accept did not start lanes")
  `MAVA_ASSERT_NEXT(a_emit_clears, emit_fire, area_q == '0 && vol_q == '0 && cnt_q == '0, "sums not cleared")
  `MAVA_ASSERT_IMPL(a_area_bound, 1'b1, !area_q[SUM_BITS-1], "area sum above limit")
  `MAVA_ASSERT_IMPL(a_vol_bound, 1'b1, vol_q != {1'b1, {(SUM_BITS-1){1'b0}}}, "volume sum below limit")

endmodule

// File: tb/mesh_area_volume_accumulator_tb.sv
// Self-checking testbench of the mesh area and volume accumulator.
// Depends on mava_pkg, the channel interfaces and the top level in src.
module mesh_area_volume_accumulator_tb;
  import mava_pkg::*;

  localparam int                 PERIOD     = 20;
  localparam int                 ITEM_LAT   = 2 * COORD_BITS_DEF + 12;
  localparam int                 RAND_ITEMS = 1550;
  localparam longint             MAX_CYCLES = 1500000;
  localparam logic [63:0]        SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint             VOL_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int                 CMIN       = -524288;
  localparam int                 CMAX       = 524287;
  localparam logic [1:0]         MODE_SPARE = 2'd3;

  typedef struct {
    logic [31:0] tri_cnt;
    logic [62:0] area;
    logic [62:0] vol;
  } mesh_sum_t;

  typedef struct {
    int        crd[9];
    bit        last;
    bit        typed;
    mesh_sum_t res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  mava_tri_if tri_if ();
  mava_res_if res_if ();
  mava_cfg_if cfg_if ();

  mesh_area_volume_accumulator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tri_in (tri_if),
    .res_out(res_if),
    .cfg    (cfg_if)
  );

  // Predictor state: running sums and the mode register copy.
  logic [63:0]        area_acc;
  logic signed [63:0] vol_acc;
  logic [31:0]        tri_acc;
  logic [1:0]         mode_cur;

  mesh_sum_t mesh_q[$];
  int        err_cnt;
  int        res_seen;
  int        items_sent;
  int        hold_req;
  bit        calm;

  // Clock.
  always begin
    clk_i = 1'b1;
    #(PERIOD / 2);
    clk_i = 1'b0;
    #(PERIOD / 2);
  end

  // Floor square root, two bits per round, of a value below 2^88.
  function automatic logic [63:0] floor_root(logic [127:0] v);
    logic [127:0] rem;
    logic [127:0] trial;
    logic [63:0]  root;
    rem  = '0;
    root = '0;
    for (int i = 43; i >= 0; i--) begin
      rem   = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [127:0] mag_sq(longint k);
    logic [127:0] m;
    m = (k < 0) ? 128'(-k) : 128'(k);
    return m * m;
  endfunction

  // The coordinate as the block sees it: low 20 bits, sign-extended.
  function automatic longint coord_of(int c);
    logic [19:0] f;
    f = c[19:0];
    return longint'($signed(f));
  endfunction

  // Accumulates one triangle; returns 1 with the mesh sums on a last triangle.
  function automatic bit mesh_update(int crd[9], bit last, output mesh_sum_t r);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint ux, uy, uz, vx, vy, vz, dv;
    logic [63:0] da;
    bit do_area;
    bit do_vol;
    ax = coord_of(crd[0]); ay = coord_of(crd[1]); az = coord_of(crd[2]);
    bx = coord_of(crd[3]); by = coord_of(crd[4]); bz = coord_of(crd[5]);
    cx = coord_of(crd[6]); cy = coord_of(crd[7]); cz = coord_of(crd[8]);
    do_area = (mode_cur != MODE_VOLUME);
    do_vol  = (mode_cur != MODE_AREA);
    if (do_area) begin
      ux = bx - ax; uy = by - ay; uz = bz - az;
      vx = cx - bx; vy = cy - by; vz = cz - bz;
      da = floor_root(mag_sq(uy * vz - uz * vy) + mag_sq(uz * vx - ux * vz)
                      + mag_sq(ux * vy - uy * vx));
      if (da > SUM_MAX - area_acc) area_acc = SUM_MAX;
      else area_acc = area_acc + da;
    end
    if (do_vol) begin
      dv = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
      if (dv > 0 && vol_acc > VOL_MAX - dv) vol_acc = VOL_MAX;
      else if (dv < 0 && vol_acc < -VOL_MAX - dv) vol_acc = -VOL_MAX;
      else vol_acc = vol_acc + dv;
    end
    if (tri_acc != 32'hFFFF_FFFF) tri_acc = tri_acc + 1;
    r.tri_cnt = tri_acc;
    r.area    = do_area ? area_acc[62:0] : '0;
    r.vol     = do_vol ? ((vol_acc < 0) ? 63'(-vol_acc) : 63'(vol_acc)) : '0;
    if (last) begin
      area_acc = '0;
      vol_acc  = '0;
      tri_acc  = '0;
    end
    return last;
  endfunction

  // Idle length: mostly none or short, sometimes long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 70);
  endfunction

  function automatic int pick_coord(int kind);
    case (kind)
      0: return int'($signed(20'($urandom)));
      1: return $urandom_range(0, 64) - 32;
      default: begin
        case ($urandom_range(0, 3))
          0: return CMIN;
          1: return CMAX;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Offers one triangle after a random gap and records its expectation.
  task automatic send_tri(int crd[9], bit last, bit typed, mesh_sum_t typed_res);
    int        gap;
    mesh_sum_t r;
    gap = pick_gap();
    if (gap > 0) begin
      tri_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tri_if.a_x <= crd[0][19:0]; tri_if.a_y <= crd[1][19:0]; tri_if.a_z <= crd[2][19:0];
    tri_if.b_x <= crd[3][19:0]; tri_if.b_y <= crd[4][19:0]; tri_if.b_z <= crd[5][19:0];
    tri_if.c_x <= crd[6][19:0]; tri_if.c_y <= crd[7][19:0]; tri_if.c_z <= crd[8][19:0];
    tri_if.last_triangle <= last;
    tri_if.valid <= 1'b1;
    do @(posedge clk_i); while (!tri_if.ready);
    items_sent++;
    if (mesh_update(crd, last, r)) mesh_q.push_back(typed ? typed_res : r);
  endtask

  // Waits until the block is idle, then writes the mode register.
  task automatic write_mode(logic [1:0] m);
    tri_if.valid <= 1'b0;
    while (mesh_q.size() != 0) @(posedge clk_i);
    repeat (ITEM_LAT) @(posedge clk_i);
    cfg_if.mode  <= m;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    mode_cur = m;
  endtask

  // Result side: random ready, long hold-offs on request, and the checker.
  int hold_left;
  int stall_left;
  int hold_seen;
  always @(posedge clk_i) begin
    mesh_sum_t e;
    if (res_if.valid && res_if.ready) begin
      res_seen++;
      if (mesh_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with nothing expected, count %0d", $time,
                 res_if.triangle_count);
      end else begin
        e = mesh_q.pop_front();
        if (res_if.triangle_count !== e.tri_cnt || res_if.twice_area_sum !== e.area ||
            res_if.six_volume_abs !== e.vol) begin
          err_cnt++;
          $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                   e.tri_cnt, e.area, e.vol, res_if.triangle_count,
                   res_if.twice_area_sum, res_if.six_volume_abs);
        end
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      res_if.ready <= (stall_left == 0);
    end
  end

  // Watchdog.
  initial begin
    #(MAX_CYCLES * PERIOD);
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence: reset, directed table, random meshes, drain.
  initial begin
    dir_row_t  rows[$];
    dir_row_t  row;
    int        crd[9];
    int        kind;
    int        len;
    int        had;
    mesh_sum_t none;
    logic [1:0] modes[4];
    had = 0; hold_seen = 0; hold_req = 0; hold_left = 0; stall_left = 0;
    err_cnt = 0; res_seen = 0; items_sent = 0; calm = 0;
    none = '{default: '0};
    area_acc = '0; vol_acc = '0; tri_acc = '0; mode_cur = MODE_BOTH;
    rst_ni = 1'b0;
    tri_if.valid = 1'b0;
    tri_if.a_x = '0; tri_if.a_y = '0; tri_if.a_z = '0;
    tri_if.b_x = '0; tri_if.b_y = '0; tri_if.b_z = '0;
    tri_if.c_x = '0; tri_if.c_y = '0; tri_if.c_z = '0;
    tri_if.last_triangle = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.mode = MODE_BOTH;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: degenerate, unit, extreme and largest-volume triangles.
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 1, '{1, 0, 0}});
    rows.push_back('{'{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1, 1, '{1, 1, 1}});
    rows.push_back('{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1, 1,
                     '{1, 0, 0}});
    rows.push_back('{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1, 1,
                     '{1, 0, 0}});
    rows.push_back('{'{CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN}, 1, 0,
                     none});
    rows.push_back('{'{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN}, 0, 0, none});
    rows.push_back('{'{CMAX, CMIN, 0, 0, CMAX, CMIN, CMIN, 0, CMAX}, 0, 0, none});
    rows.push_back('{'{-1, -1, -1, 1, 2, 3, CMAX, 0, CMIN}, 1, 0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_tri(row.crd, row.last, row.typed, row.res);
    end
    modes = '{MODE_AREA, MODE_VOLUME, MODE_BOTH, MODE_SPARE};
    foreach (modes[m]) begin
      write_mode(modes[m]);
      send_tri(rows[5].crd, 0, 0, none);
      send_tri(rows[4].crd, 1, 0, none);
    end

    // Random phases of whole meshes; a phase may end with its mesh still open.
    for (int ph = 0; items_sent < RAND_ITEMS + 30; ph++) begin
      write_mode((ph < 4) ? modes[ph] : 2'($urandom));
      calm = ($urandom_range(0, 5) == 0);
      if (ph == 3) begin
        // Volume saturation: many largest-volume triangles in one mesh.
        for (int k = 0; k < 20; k++) begin
          crd = rows[4].crd;
          if (ph[0] ^ (k > 25)) foreach (crd[j]) crd[j] = crd[j];
          send_tri(crd, k == 19, 0, none);
        end
        for (int k = 0; k < 20; k++) begin
          crd = rows[4].crd;
          crd[0] = CMAX; crd[1] = CMAX; crd[2] = CMIN;
          send_tri(crd, k == 19, 0, none);
        end
      end
      if (ph == 5) begin
        // Long hold-off on results while triangles keep coming.
        hold_req++;
        for (int k = 0; k < 6; k++) begin
          foreach (crd[j]) crd[j] = pick_coord(1);
          send_tri(crd, 1, 0, none);
        end
      end
      for (int msh = 0; msh < 6; msh++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          kind = $urandom_range(0, 9);
          kind = (kind < 5) ? 0 : (kind < 8) ? 1 : 2;
          foreach (crd[j]) crd[j] = pick_coord(kind);
          if ($urandom_range(0, 19) == 0) begin
            crd[3] = crd[0]; crd[4] = crd[1]; crd[5] = crd[2];
          end
          send_tri(crd, (k == len - 1) && ($urandom_range(0, 9) != 0), 0, none);
        end
      end
    end

    // Drain.
    tri_if.valid <= 1'b0;
    while (mesh_q.size() != 0) @(posedge clk_i);
    repeat (ITEM_LAT * 2) @(posedge clk_i);
    $display("Sent %0d triangles, checked %0d mesh results across all four mode codes,",
             items_sent, res_seen);
    $display("including volume saturation and a long result hold-off.");
    if (err_cnt == 0 && mesh_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
